### sv/rga_pkg.sv
// ----------------------------------------------------------------------------
// Rational ALU package
// Opcodes, shared-unit operation codes and the unit status struct.
// ----------------------------------------------------------------------------
package rga_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OPC_ADD = 2'd0;
   localparam opcode_type OPC_SUB = 2'd1;
   localparam opcode_type OPC_MUL = 2'd2;
   localparam opcode_type OPC_DIV = 2'd3;

   typedef logic [1:0] unit_op_type;

   localparam unit_op_type UOP_ADD = 2'd0;
   localparam unit_op_type UOP_SUB = 2'd1;
   localparam unit_op_type UOP_MUL = 2'd2;
   localparam unit_op_type UOP_DIV = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### sv/rga_if.sv
// ----------------------------------------------------------------------------
// Rational ALU channel interfaces
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface rga_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic signed [31:0] b_den;

   modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rga_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] res_num;
   logic signed [31:0] res_den;
   logic              den_is_zero;

   modport source (output valid, res_num, res_den, den_is_zero, input ready);
   modport sink   (input valid, res_num, res_den, den_is_zero, output ready);
endinterface

### sv/rational_alu_with_gcd_reduce.sv
// ----------------------------------------------------------------------------
// Rational ALU with gcd reduction
// Multiplies out two signed fractions (crosswise but for MUL), then reduces the
// pair by the Euclidean gcd, all through one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Each item runs its steps one at a time in the shared unit: 2 or 3 products,
// an add or subtract for ADD and SUB, then, for a nonzero numerator, the gcd
// remainder steps and two final divides. The request side is ready only when
// idle, so a new item is taken only after the last result is registered.
// Reset clears the sequencer and the result valid; no stored data is cleared.
module rational_alu_with_gcd_reduce #(
   parameter int WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   rga_req_if.sink    req_bus,
   rga_rsp_if.source  rsp_bus
);
   import rga_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_P0   = 4'd1;
   localparam logic [3:0] S_P1   = 4'd2;
   localparam logic [3:0] S_COMB = 4'd3;
   localparam logic [3:0] S_P2   = 4'd4;
   localparam logic [3:0] S_GCD  = 4'd5;
   localparam logic [3:0] S_DN   = 4'd6;
   localparam logic [3:0] S_DD   = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic               launch_ff, launch_in;
   opcode_type         opc_ff, opc_in;
   logic [WIDTH-1:0]   an_ff, an_in;
   logic [WIDTH-1:0]   ad_ff, ad_in;
   logic [WIDTH-1:0]   bn_ff, bn_in;
   logic [WIDTH-1:0]   bd_ff, bd_in;
   logic [WIDTH-1:0]   n_ff, n_in;
   logic [WIDTH-1:0]   p1_ff, p1_in;
   logic [WIDTH-1:0]   d_ff, d_in;
   logic [WIDTH-1:0]   ga_ff, ga_in;
   logic [WIDTH-1:0]   gb_ff, gb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_num_ff, rsp_num_in;
   logic signed [31:0] rsp_den_ff, rsp_den_in;
   logic               rsp_dz_ff, rsp_dz_in;

   logic               u_start;
   unit_op_type        u_op;
   logic [WIDTH-1:0]   u_opa;
   logic [WIDTH-1:0]   u_opb;
   unit_stat_type      u_stat;
   logic [WIDTH-1:0]   u_q;
   logic [WIDTH-1:0]   u_r;
   logic               req_beat;
   logic               rsp_free;

   rga_unit #(
      .WIDTH (WIDTH)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .start (u_start),
      .op    (u_op),
      .opa   (u_opa),
      .opb   (u_opb),
      .stat  (u_stat),
      .res_q (u_q),
      .res_r (u_r)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      u_op  = UOP_MUL;
      u_opa = an_ff;
      u_opb = bd_ff;
      unique case (state_ff)
         S_P0: begin
            u_opb = (opc_ff == OPC_MUL) ? bn_ff : bd_ff;
         end
         S_P1: begin
            u_opa = bn_ff;
            u_opb = ad_ff;
         end
         S_COMB: begin
            u_op  = (opc_ff == OPC_SUB) ? UOP_SUB : UOP_ADD;
            u_opa = n_ff;
            u_opb = p1_ff;
         end
         S_P2: begin
            u_opa = ad_ff;
            u_opb = (opc_ff == OPC_DIV) ? bn_ff : bd_ff;
         end
         S_GCD: begin
            u_op  = UOP_DIV;
            u_opa = ga_ff;
            u_opb = gb_ff;
         end
         S_DN: begin
            u_op  = UOP_DIV;
            u_opa = n_ff;
            u_opb = ga_ff;
         end
         S_DD: begin
            u_op  = UOP_DIV;
            u_opa = d_ff;
            u_opb = ga_ff;
         end
         default: begin
            u_op = UOP_MUL;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      launch_in    = launch_ff;
      opc_in       = opc_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      n_in         = n_ff;
      p1_in        = p1_ff;
      d_in         = d_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_dz_in    = rsp_dz_ff;
      u_start      = 1'b0;

      if (state_ff == S_P0 || state_ff == S_P1 || state_ff == S_COMB ||
          state_ff == S_P2 || state_ff == S_DN || state_ff == S_DD ||
          (state_ff == S_GCD && gb_ff != '0)) begin
         if (!launch_ff) begin
            u_start   = 1'b1;
            launch_in = 1'b1;
         end else if (u_stat.done) begin
            launch_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               opc_in   = req_bus.opcode;
               an_in    = WIDTH'(req_bus.a_num);
               ad_in    = WIDTH'(req_bus.a_den);
               bn_in    = WIDTH'(req_bus.b_num);
               bd_in    = WIDTH'(req_bus.b_den);
               state_in = S_P0;
            end
         end
         S_P0: begin
            if (launch_ff && u_stat.done) begin
               n_in     = u_q;
               state_in = (opc_ff == OPC_ADD || opc_ff == OPC_SUB) ? S_P1 : S_P2;
            end
         end
         S_P1: begin
            if (launch_ff && u_stat.done) begin
               p1_in    = u_q;
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            if (launch_ff && u_stat.done) begin
               n_in     = u_q;
               state_in = S_P2;
            end
         end
         S_P2: begin
            if (launch_ff && u_stat.done) begin
               if (n_ff == '0) begin
                  d_in     = WIDTH'(1);
                  state_in = S_OUT;
               end else begin
                  d_in     = u_q;
                  ga_in    = n_ff;
                  gb_in    = u_q;
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (gb_ff == '0) begin
               state_in = (ga_ff == '0) ? S_OUT : S_DN;
            end else if (launch_ff && u_stat.done) begin
               ga_in = gb_ff;
               gb_in = u_r;
            end
         end
         S_DN: begin
            if (launch_ff && u_stat.done) begin
               n_in     = u_q;
               state_in = S_DD;
            end
         end
         S_DD: begin
            if (launch_ff && u_stat.done) begin
               d_in     = u_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = 32'(signed'(n_ff));
               rsp_den_in   = 32'(signed'(d_ff));
               rsp_dz_in    = (d_ff == '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opc_ff     <= opc_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      n_ff       <= n_in;
      p1_ff      <= p1_in;
      d_ff       <= d_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_dz_ff  <= rsp_dz_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.res_num     = rsp_num_ff;
   assign rsp_bus.res_den     = rsp_den_ff;
   assign rsp_bus.den_is_zero = rsp_dz_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      u_start |-> !u_stat.busy)
      else $error("shared unit started while busy");

   a_done_launched: assert property (@(posedge clock) disable iff (reset)
      u_stat.done |-> launch_ff)
      else $error("shared unit finished without a pending launch");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == S_P0))
      else $error("accepted beat did not start the product phase");

   a_flag_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.res_den != 32'sd0) |-> !rsp_bus.den_is_zero)
      else $error("zero-denominator flag set on a nonzero denominator");

endmodule

### sv/rga_unit.sv
// ----------------------------------------------------------------------------
// Rational ALU shared arithmetic unit
// One adder used for add and subtract, bit-serial shift-add
// multiply and restoring signed division with truncating remainder.
// ----------------------------------------------------------------------------
module rga_unit #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rga_pkg::unit_op_type  op,
   input  logic [WIDTH-1:0]      opa,
   input  logic [WIDTH-1:0]      opb,
   output rga_pkg::unit_stat_type stat,
   output logic [WIDTH-1:0]      res_q,
   output logic [WIDTH-1:0]      res_r
);
   import rga_pkg::*;

   localparam int CW = $clog2(WIDTH);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic [WIDTH-1:0]  x_ff, x_in;
   logic [WIDTH-1:0]  y_ff, y_in;
   logic              sq_ff, sq_in;
   logic              sr_ff, sr_in;
   logic [WIDTH-1:0]  q_ff, q_in;
   logic [WIDTH-1:0]  r_ff, r_in;

   logic [WIDTH-1:0]  r2;
   logic [WIDTH-1:0]  lhs;
   logic              sub;
   logic [WIDTH:0]    sum;
   logic [WIDTH-1:0]  abs_a;
   logic [WIDTH-1:0]  abs_b;

   always_comb begin
      r2    = {acc_ff[WIDTH-2:0], y_ff[WIDTH-1]};
      lhs   = (op_ff == UOP_DIV) ? r2 : acc_ff;
      sub   = (op_ff == UOP_DIV) || (op_ff == UOP_SUB);
      sum   = {1'b0, lhs} + {1'b0, (sub ? ~x_ff : x_ff)} + {{WIDTH{1'b0}}, sub};
      abs_a = opa[WIDTH-1] ? (WIDTH'(0) - opa) : opa;
      abs_b = opb[WIDTH-1] ? (WIDTH'(0) - opb) : opb;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      sq_in   = sq_ff;
      sr_in   = sr_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (busy_ff) begin
         unique case (op_ff)
            UOP_MUL: begin
               if (y_ff[0]) begin
                  acc_in = sum[WIDTH-1:0];
               end
               x_in = {x_ff[WIDTH-2:0], 1'b0};
               y_in = {1'b0, y_ff[WIDTH-1:1]};
            end
            UOP_DIV: begin
               acc_in = sum[WIDTH] ? sum[WIDTH-1:0] : r2;
               y_in   = {y_ff[WIDTH-2:0], sum[WIDTH]};
            end
            default: begin
               acc_in = sum[WIDTH-1:0];
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == UOP_DIV) begin
               q_in = sq_ff ? (WIDTH'(0) - y_in) : y_in;
               r_in = sr_ff ? (WIDTH'(0) - acc_in) : acc_in;
            end else begin
               q_in = acc_in;
               r_in = '0;
            end
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end else if (start) begin
         op_in = op;
         unique case (op)
            UOP_MUL: begin
               busy_in = 1'b1;
               cnt_in  = CW'(WIDTH - 1);
               acc_in  = '0;
               x_in    = opa;
               y_in    = opb;
            end
            UOP_DIV: begin
               if (opb == '0) begin
                  done_in = 1'b1;
                  q_in    = opa;
                  r_in    = '0;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = CW'(WIDTH - 1);
                  acc_in  = '0;
                  x_in    = abs_b;
                  y_in    = abs_a;
                  sq_in   = opa[WIDTH-1] ^ opb[WIDTH-1];
                  sr_in   = opa[WIDTH-1];
               end
            end
            default: begin
               busy_in = 1'b1;
               cnt_in  = '0;
               acc_in  = opa;
               x_in    = opb;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      sq_ff  <= sq_in;
      sr_ff  <= sr_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign res_q     = q_ff;
   assign res_r     = r_ff;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Rational ALU testbench
// Sends fraction pairs with every opcode through the operand channel and
// checks each reduced result against a predictor running alongside. A short
// directed set covers extreme values, zero numerators and denominators, and
// the wrap cases of the gcd reduction. Random pairs follow, with random gaps
// on both channels and one long result stall that backs up the operand side.
// ----------------------------------------------------------------------------
module tb;
   import rga_pkg::*;

   localparam int RANDOM_BEATS   = 880;
   localparam int HOLD_OFF       = 3000;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int TAIL_CYCLES    = 100;
   localparam int MAX_REPORTS    = 10;
   localparam int INT_MAX        = 32'sh7FFF_FFFF;
   localparam int INT_MIN        = 32'sh8000_0000;

   typedef struct {
      opcode_type opcode;
      int         a_num;
      int         a_den;
      int         b_num;
      int         b_den;
   } operand_beat_type;

   typedef struct {
      int   res_num;
      int   res_den;
      logic den_is_zero;
   } reduced_frac_type;

   logic clock;
   logic reset;

   rga_req_if req_bus ();
   rga_rsp_if rsp_bus ();

   rational_alu_with_gcd_reduce dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   operand_beat_type pending_operands[$];
   reduced_frac_type awaited_results[$];
   int               total_beats;
   int               beats_sent;
   int               results_checked;
   int               mismatches;
   int               stall_cycles;
   bit               req_taken;
   int               send_gap;
   int               rsp_hold;
   bit               pressure_done;

   always #10 clock = ~clock;

   // Truncating remainder that yields zero for a divisor of zero or minus one.
   function automatic int trunc_rem(int a, int b);
      if (b == 0 || b == -1) begin
         return 0;
      end
      return a % b;
   endfunction

   // Truncating quotient; a zero divisor passes the dividend, minus one wraps.
   function automatic int trunc_div(int a, int b);
      if (b == 0) begin
         return a;
      end
      if (b == -1) begin
         return -a;
      end
      return a / b;
   endfunction

   function automatic reduced_frac_type reduce_rational(operand_beat_type beat);
      int               n;
      int               d;
      int               x;
      int               y;
      int               r;
      reduced_frac_type res;
      n = 0;
      d = 0;
      case (beat.opcode)
         OPC_ADD: begin
            n = beat.a_num * beat.b_den + beat.b_num * beat.a_den;
            d = beat.a_den * beat.b_den;
         end
         OPC_SUB: begin
            n = beat.a_num * beat.b_den - beat.b_num * beat.a_den;
            d = beat.a_den * beat.b_den;
         end
         OPC_MUL: begin
            n = beat.a_num * beat.b_num;
            d = beat.a_den * beat.b_den;
         end
         OPC_DIV: begin
            n = beat.a_num * beat.b_den;
            d = beat.a_den * beat.b_num;
         end
      endcase
      if (n == 0) begin
         d = 1;
      end else begin
         x = n;
         y = d;
         while (y != 0) begin
            r = trunc_rem(x, y);
            x = y;
            y = r;
         end
         if (x != 0) begin
            n = trunc_div(n, x);
            d = trunc_div(d, x);
         end
      end
      res.res_num     = n;
      res.res_den     = d;
      res.den_is_zero = (d == 0);
      return res;
   endfunction

   task automatic add_beat(opcode_type op, int an, int ad, int bn, int bd);
      operand_beat_type beat;
      beat.opcode = op;
      beat.a_num  = an;
      beat.a_den  = ad;
      beat.b_num  = bn;
      beat.b_den  = bd;
      pending_operands.push_back(beat);
   endtask

   function automatic int random_operand();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: return int'($urandom);
         3, 4, 5: return int'($urandom_range(0, 200)) - 100;
         6: return int'($urandom_range(1, 5000)) * int'($urandom_range(1, 5000));
         7: begin
            case ($urandom_range(0, 4))
               0: return 0;
               1: return 1;
               2: return -1;
               3: return INT_MAX;
               default: return INT_MIN;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               return -(1 << $urandom_range(0, 31));
            end
            return 1 << $urandom_range(0, 31);
         end
      endcase
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(20, 200);
   endfunction

   // Every fourth stretch of 150 beats draws no new gaps on either side.
   function automatic bit calm_phase();
      return ((beats_sent / 150) % 4) == 3;
   endfunction

   task automatic note_mismatch(string what, reduced_frac_type expd,
                                reduced_frac_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("tb: result %0d %s: expected %0d/%0d z=%0b, got %0d/%0d z=%0b",
            results_checked, what, expd.res_num, expd.res_den, expd.den_is_zero,
            got.res_num, got.res_den, got.den_is_zero);
      end
   endtask

   always @(negedge clock) begin : driver
      if (!reset) begin
         if (!(req_bus.valid && !req_taken)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_operands.size() > 0) begin
               operand_beat_type beat;
               beat = pending_operands.pop_front();
               req_bus.opcode <= beat.opcode;
               req_bus.a_num  <= beat.a_num;
               req_bus.a_den  <= beat.a_den;
               req_bus.b_num  <= beat.b_num;
               req_bus.b_den  <= beat.b_den;
               req_bus.valid  <= 1'b1;
               send_gap = calm_phase() ? 0 : idle_length();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (!pressure_done && results_checked >= 40) begin
            pressure_done = 1'b1;
            rsp_hold = HOLD_OFF;
         end else if (rsp_hold == 0 && !calm_phase() && $urandom_range(0, 7) == 0) begin
            rsp_hold = idle_length();
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      operand_beat_type beat;
      reduced_frac_type expd;
      reduced_frac_type got;
      bit               progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            beat.opcode = req_bus.opcode;
            beat.a_num  = req_bus.a_num;
            beat.a_den  = req_bus.a_den;
            beat.b_num  = req_bus.b_num;
            beat.b_den  = req_bus.b_den;
            awaited_results.push_back(reduce_rational(beat));
            req_taken = 1'b1;
            beats_sent++;
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.res_num     = rsp_bus.res_num;
            got.res_den     = rsp_bus.res_den;
            got.den_is_zero = rsp_bus.den_is_zero;
            progress = 1'b1;
            if (awaited_results.size() == 0) begin
               expd = '{0, 0, 1'b0};
               note_mismatch("arrived with none outstanding", expd, got);
            end else begin
               expd = awaited_results.pop_front();
               if (got.res_num !== expd.res_num) begin
                  note_mismatch("res_num differs", expd, got);
               end else if (got.res_den !== expd.res_den) begin
                  note_mismatch("res_den differs", expd, got);
               end else if (got.den_is_zero !== expd.den_is_zero) begin
                  note_mismatch("den_is_zero differs", expd, got);
               end
            end
            results_checked++;
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.opcode  = OPC_ADD;
      req_bus.a_num   = '0;
      req_bus.a_den   = '0;
      req_bus.b_num   = '0;
      req_bus.b_den   = '0;
      rsp_bus.ready   = 1'b0;
      beats_sent      = 0;
      results_checked = 0;
      mismatches      = 0;
      stall_cycles    = 0;
      req_taken       = 1'b0;
      send_gap        = 0;
      rsp_hold        = 0;
      pressure_done   = 1'b0;

      add_beat(OPC_ADD, 1, 2, 1, 3);
      add_beat(OPC_SUB, 1, 2, 1, 2);
      add_beat(OPC_MUL, 2, 4, 3, 9);
      add_beat(OPC_DIV, 1, 2, 0, 5);
      add_beat(OPC_ADD, 0, 0, 3, 0);
      add_beat(OPC_MUL, 5, 0, 1, 1);
      add_beat(OPC_MUL, INT_MIN, -1, 1, 1);
      add_beat(OPC_ADD, INT_MAX, 1, INT_MAX, 1);
      add_beat(OPC_MUL, INT_MIN, INT_MIN, -1, -1);
      add_beat(OPC_SUB, -1, -1, INT_MAX, INT_MIN);
      add_beat(OPC_DIV, INT_MAX, INT_MIN, INT_MIN, INT_MAX);
      add_beat(OPC_MUL, -6, 4, 1, 1);
      add_beat(OPC_DIV, -7, 3, -14, 9);
      add_beat(OPC_ADD, -1, -1, -1, -1);
      add_beat(OPC_MUL, 0, 0, 0, 0);
      add_beat(OPC_DIV, 1, 1, INT_MIN, 1);
      add_beat(OPC_MUL, 65536, 65536, 65536, 65536);
      add_beat(OPC_SUB, INT_MIN, 1, INT_MAX, 1);
      add_beat(OPC_DIV, 0, 7, 0, 3);
      add_beat(OPC_ADD, 12, -18, -8, 27);
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         add_beat(opcode_type'($urandom_range(0, 3)), random_operand(), random_operand(),
            random_operand(), random_operand());
      end
      total_beats = pending_operands.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do begin
         @(negedge clock);
      end while (beats_sent < total_beats || awaited_results.size() > 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
